/* sv/jrd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrd_pkg
// Shared types, constants and the CRC-32C byte update for the journal record
// deframer.
// ----------------------------------------------------------------------------
package jrd_pkg;

    localparam int HEADER_BYTES = 36;
    localparam int CRC_SPAN     = 32;
    localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);

    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND   = 2'd2;

    localparam logic [31:0] MAGIC_RESET   = 32'd0;
    localparam logic [15:0] VERSION_RESET = 16'd1;
    localparam logic [31:0] BOUND_RESET   = 32'd4 * 32'd1024 * 32'd1024;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_HALT
    } t_phase;

    typedef enum logic [2:0] {
        V_OK      = 3'd0,
        V_TRUNC   = 3'd1,
        V_CORRUPT = 3'd2,
        V_VERSION = 3'd3,
        V_BOUNDS  = 3'd4
    } t_verdict;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        t_verdict    verdict;
        logic [15:0] record_kind;
        logic [63:0] sequence_number;
        logic [63:0] transaction_id;
        logic [31:0] payload_length;
        logic        last_of_run;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_push;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* sv/jrd_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrd_in_if
// Input channel of the deframer: one journal byte per item.
// ----------------------------------------------------------------------------
interface jrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       end_of_buffer;

    modport source (output valid, output stream_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input stream_byte, input end_of_buffer, output ready);
endinterface

/* sv/jrd_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrd_out_if
// Output channel of the deframer: a forwarded payload byte or a verdict.
// ----------------------------------------------------------------------------
interface jrd_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [2:0]  verdict;
    logic [15:0] record_kind;
    logic [63:0] sequence_number;
    logic [63:0] transaction_id;
    logic [31:0] payload_length;
    logic        last_of_run;

    modport source (
        output valid, output result_kind, output payload_byte, output verdict,
        output record_kind, output sequence_number, output transaction_id,
        output payload_length, output last_of_run, input ready
    );
    modport sink (
        input valid, input result_kind, input payload_byte, input verdict,
        input record_kind, input sequence_number, input transaction_id,
        input payload_length, input last_of_run, output ready
    );
endinterface

/* sv/jrd_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrd_parser
// Record parser: header capture, CRC-32C update, checks and result building
// for one byte per cycle while the result queue has room (i_space).
// ----------------------------------------------------------------------------
module jrd_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_byte,
    input  logic           i_eob,
    input  logic           i_space,
    output logic           o_ready,
    input  logic [31:0]    i_magic,
    input  logic [15:0]    i_version,
    input  logic [31:0]    i_bound,
    output jrd_pkg::t_push o_push
);
    import jrd_pkg::*;

    t_phase                r_phase, n_phase;
    logic [HDR_IDX_W-1:0]  r_count, n_count;
    logic [31:0]           r_rem, n_rem;
    logic [31:0]           r_crc, n_crc;
    logic [7:0]            r_hdr [HEADER_BYTES];

    logic        w_acc;
    logic [31:0] w_magic, w_flags, w_len, w_stored_crc, w_crc_next;
    logic [15:0] w_ver, w_kind;
    logic [63:0] w_seq, w_tid;
    t_verdict    w_chk;
    logic        w_hdr_last, w_crc_hdr_ok, w_crc_pay_ok;
    logic        d_pay, d_ver, d_with_hdr;
    t_verdict    d_v;
    t_result     w_vrec, w_prec;

    assign o_ready = i_space;
    assign w_acc   = i_valid && i_space;

    assign w_magic      = {r_hdr[3], r_hdr[2], r_hdr[1], r_hdr[0]};
    assign w_ver        = {r_hdr[5], r_hdr[4]};
    assign w_kind       = {r_hdr[7], r_hdr[6]};
    assign w_flags      = {r_hdr[11], r_hdr[10], r_hdr[9], r_hdr[8]};
    assign w_seq        = {r_hdr[19], r_hdr[18], r_hdr[17], r_hdr[16],
                           r_hdr[15], r_hdr[14], r_hdr[13], r_hdr[12]};
    assign w_tid        = {r_hdr[27], r_hdr[26], r_hdr[25], r_hdr[24],
                           r_hdr[23], r_hdr[22], r_hdr[21], r_hdr[20]};
    assign w_len        = {r_hdr[31], r_hdr[30], r_hdr[29], r_hdr[28]};
    assign w_stored_crc = {r_hdr[35], r_hdr[34], r_hdr[33], r_hdr[32]};

    assign w_crc_next   = crc_byte(r_crc, i_byte);
    assign w_hdr_last   = (r_count == HDR_IDX_W'(HEADER_BYTES - 1));
    // On the last header byte the final stored-CRC byte is still on the input.
    assign w_crc_hdr_ok = (~r_crc) == {i_byte, r_hdr[34], r_hdr[33], r_hdr[32]};
    assign w_crc_pay_ok = (~w_crc_next) == w_stored_crc;

    always_comb begin
        if (w_magic != i_magic) begin
            w_chk = V_CORRUPT;
        end else if (w_ver != i_version) begin
            w_chk = V_VERSION;
        end else if (w_flags != 32'd0) begin
            w_chk = V_CORRUPT;
        end else if (w_len > i_bound) begin
            w_chk = V_BOUNDS;
        end else begin
            w_chk = V_OK;
        end
    end

    always_comb begin
        d_pay      = 1'b0;
        d_ver      = 1'b0;
        d_with_hdr = 1'b1;
        d_v        = V_OK;
        case (r_phase)
            PH_HEADER: begin
                if (w_hdr_last) begin
                    if (w_chk != V_OK) begin
                        d_ver = 1'b1;
                        d_v   = w_chk;
                    end else if (w_len == 32'd0) begin
                        d_ver = 1'b1;
                        d_v   = w_crc_hdr_ok ? V_OK : V_CORRUPT;
                    end else if (i_eob) begin
                        d_ver = 1'b1;
                        d_v   = V_TRUNC;
                    end
                end else if (i_eob) begin
                    d_ver      = 1'b1;
                    d_v        = V_TRUNC;
                    d_with_hdr = 1'b0;
                end
            end
            PH_PAYLOAD: begin
                if (r_rem != 32'd0) begin
                    d_pay = 1'b1;
                    if (r_rem == 32'd1) begin
                        d_ver = 1'b1;
                        d_v   = w_crc_pay_ok ? V_OK : V_CORRUPT;
                    end else if (i_eob) begin
                        d_ver = 1'b1;
                        d_v   = V_TRUNC;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_rem   = r_rem;
        n_crc   = r_crc;
        if (w_acc) begin
            case (r_phase)
                PH_HEADER: begin
                    n_count = r_count + HDR_IDX_W'(1);
                    if (r_count < HDR_IDX_W'(CRC_SPAN)) begin
                        n_crc = w_crc_next;
                    end
                    if (w_hdr_last && !d_ver) begin
                        n_phase = PH_PAYLOAD;
                        n_rem   = w_len;
                    end
                end
                PH_PAYLOAD: begin
                    if (r_rem != 32'd0) begin
                        n_crc = w_crc_next;
                        n_rem = r_rem - 32'd1;
                    end
                end
                default: begin
                end
            endcase
            if ((d_ver && (d_v != V_OK) && !i_eob)) begin
                n_phase = PH_HALT;
            end else if (d_ver || i_eob) begin
                n_phase = PH_HEADER;
                n_count = '0;
                n_rem   = 32'd0;
                n_crc   = CRC_INIT;
            end
        end
    end

    // Outputs.
    always_comb begin
        w_prec              = '0;
        w_prec.payload_byte = i_byte;
        w_vrec              = '0;
        w_vrec.result_kind  = 1'b1;
        w_vrec.verdict      = d_v;
        if (d_with_hdr) begin
            w_vrec.record_kind     = w_kind;
            w_vrec.sequence_number = w_seq;
            w_vrec.transaction_id  = w_tid;
            w_vrec.payload_length  = w_len;
        end
        o_push = '0;
        if (w_acc) begin
            o_push.count = {1'b0, d_pay} + {1'b0, d_ver};
            o_push.r0    = d_pay ? w_prec : w_vrec;
            o_push.r1    = w_vrec;
            if (d_pay && d_ver) begin
                o_push.r1.last_of_run = 1'b1;
            end else begin
                o_push.r0.last_of_run = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_count <= '0;
            r_rem   <= 32'd0;
            r_crc   <= CRC_INIT;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_rem   <= n_rem;
            r_crc   <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && (r_phase == PH_HEADER)) begin
            r_hdr[r_count] <= i_byte;
        end
    end

`ifndef ASSERT_OFF
    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_rem != 32'd0))
        else $error("payload phase with no bytes remaining");
    a_header_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |-> (r_count < HDR_IDX_W'(HEADER_BYTES)))
        else $error("header count out of range");
    a_eob_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_eob) |=> ((r_phase == PH_HEADER) && (r_count == '0)
                              && (r_crc == CRC_INIT)))
        else $error("no restart after end of buffer");
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count == 2'd2) |-> (!o_push.r0.result_kind && o_push.r1.result_kind
                                   && !o_push.r0.last_of_run && o_push.r1.last_of_run))
        else $error("bad order of a result pair");
`endif

endmodule

/* sv/jrd_out_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrd_out_fifo
// Result queue that takes up to two results per cycle and hands out one.
// ----------------------------------------------------------------------------
module jrd_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  jrd_pkg::t_push   i_push,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output jrd_pkg::t_result o_data
);
    import jrd_pkg::*;

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr, n_wr, r_rd, n_rd;
    logic [FIFO_CW-1:0]   r_count, n_count;
    logic                 w_pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign o_space = (r_count <= FIFO_CW'(FIFO_DEPTH - 2));
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_wr    = r_wr + FIFO_AW'(i_push.count);
        n_rd    = r_rd + FIFO_AW'(w_pop);
        n_count = r_count + FIFO_CW'(i_push.count) - FIFO_CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + FIFO_AW'(1)] <= i_push.r1;
        end
    end

endmodule

/* sv/journal_record_deframer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// journal_record_deframer_core
// Length-prefixed journal record deframer with CRC-32C checking.
// Results are registered in the result queue before they are presented.
// Throughput: one byte per cycle; the parser takes a byte whenever the
// four-entry result queue has room for two results.
// A final payload byte yields two results, drained one per cycle on ready.
// Reset: synchronous active low; clears parser and queue, presets config.
// ----------------------------------------------------------------------------
module journal_record_deframer_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    jrd_in_if.sink                           i_in,
    jrd_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [jrd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [jrd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import jrd_pkg::*;

    logic [31:0] r_magic;
    logic [15:0] r_version;
    logic [31:0] r_bound;
    t_push       w_push;
    logic        w_space;
    t_result     w_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= MAGIC_RESET;
            r_version <= VERSION_RESET;
            r_bound   <= BOUND_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAGIC:   r_magic   <= i_cfg_data[31:0];
                CFG_VERSION: r_version <= i_cfg_data[15:0];
                CFG_BOUND:   r_bound   <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    jrd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_byte    (i_in.stream_byte),
        .i_eob     (i_in.end_of_buffer),
        .i_space   (w_space),
        .o_ready   (i_in.ready),
        .i_magic   (r_magic),
        .i_version (r_version),
        .i_bound   (r_bound),
        .o_push    (w_push)
    );

    jrd_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_space (w_space),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (w_data)
    );

    assign o_out.result_kind     = w_data.result_kind;
    assign o_out.payload_byte    = w_data.payload_byte;
    assign o_out.verdict         = w_data.verdict;
    assign o_out.record_kind     = w_data.record_kind;
    assign o_out.sequence_number = w_data.sequence_number;
    assign o_out.transaction_id  = w_data.transaction_id;
    assign o_out.payload_length  = w_data.payload_length;
    assign o_out.last_of_run     = w_data.last_of_run;

endmodule

/* tb/sv/tb_journal_record_deframer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_journal_record_deframer_core
// Self-checking bench for the journal record deframer. Journal buffers are
// built from records with valid or deliberately damaged headers, CRCs and
// lengths, then cut short at random. A predictor follows every accepted item
// and queues the payload bytes and verdicts the block must return. Results
// are checked field by field in order while both sides idle and stall at
// random.
// ----------------------------------------------------------------------------
module tb_journal_record_deframer_core;
    import jrd_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;

    typedef enum int {
        FLAW_NONE,
        FLAW_MAGIC,
        FLAW_VERSION,
        FLAW_FLAGS,
        FLAW_CRC
    } t_flaw;

    class record_ledger;
        t_result     expected_results[$];
        int          failures;
        logic [31:0] magic_reg;
        logic [15:0] version_reg;
        logic [31:0] bound_reg;
        t_phase      phase;
        int          hdr_count;
        logic [7:0]  hdr [HEADER_BYTES];
        logic [31:0] remaining;
        logic [31:0] crc;

        function new();
            magic_reg   = MAGIC_RESET;
            version_reg = VERSION_RESET;
            bound_reg   = BOUND_RESET;
            failures    = 0;
            restart();
        endfunction

        static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] d);
            logic [31:0] r;
            r = c;
            for (int i = 0; i < 8; i++) begin
                r = (r >> 1) ^ ({32{r[0] ^ d[i]}} & CRC_POLY);
            end
            return r;
        endfunction

        function void restart();
            phase     = PH_HEADER;
            hdr_count = 0;
            remaining = '0;
            crc       = CRC_INIT;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MAGIC: begin
                    magic_reg = data;
                end
                CFG_VERSION: begin
                    version_reg = data[15:0];
                end
                CFG_BOUND: begin
                    bound_reg = data;
                end
                default: begin
                end
            endcase
        endfunction

        function logic [63:0] hdr_le(int off, int nbytes);
            logic [63:0] v;
            v = '0;
            for (int i = 0; i < nbytes; i++) begin
                v[8*i +: 8] = hdr[off + i];
            end
            return v;
        endfunction

        function t_verdict header_verdict();
            logic [63:0] magic;
            logic [63:0] version;
            logic [63:0] flags;
            logic [63:0] len;
            magic   = hdr_le(0, 4);
            version = hdr_le(4, 2);
            flags   = hdr_le(8, 4);
            len     = hdr_le(28, 4);
            if (magic[31:0] != magic_reg) return V_CORRUPT;
            if (version[15:0] != version_reg) return V_VERSION;
            if (flags != 0) return V_CORRUPT;
            if (len[31:0] > bound_reg) return V_BOUNDS;
            return V_OK;
        endfunction

        function t_verdict crc_verdict();
            logic [63:0] stored;
            stored = hdr_le(32, 4);
            return (~crc == stored[31:0]) ? V_OK : V_CORRUPT;
        endfunction

        function void push_verdict(t_verdict v, bit with_hdr);
            t_result     r;
            logic [63:0] f;
            r = '0;
            r.result_kind = 1'b1;
            r.verdict     = v;
            if (with_hdr) begin
                f = hdr_le(6, 2);
                r.record_kind     = f[15:0];
                r.sequence_number = hdr_le(12, 8);
                r.transaction_id  = hdr_le(20, 8);
                f = hdr_le(28, 4);
                r.payload_length  = f[31:0];
            end
            expected_results = {expected_results, r};
        endfunction

        // A failed record halts parsing unless the same byte ends the buffer.
        function void close_record(t_verdict v, logic eob);
            if (v != V_OK && !eob) begin
                phase = PH_HALT;
            end else begin
                restart();
            end
        endfunction

        function void take_byte(logic [7:0] b, logic eob);
            int          n_prior;
            t_verdict    v;
            logic [63:0] len;
            t_result     r;
            n_prior = expected_results.size();
            if (phase == PH_HEADER) begin
                if (hdr_count < HEADER_BYTES) begin
                    hdr[hdr_count] = b;
                    if (hdr_count < CRC_SPAN) crc = crc_step(crc, b);
                    hdr_count++;
                end
                if (hdr_count >= HEADER_BYTES) begin
                    v   = header_verdict();
                    len = hdr_le(28, 4);
                    if (v != V_OK) begin
                        push_verdict(v, 1'b1);
                        close_record(v, eob);
                    end else if (len == 0) begin
                        v = crc_verdict();
                        push_verdict(v, 1'b1);
                        close_record(v, eob);
                    end else if (eob) begin
                        push_verdict(V_TRUNC, 1'b1);
                        restart();
                    end else begin
                        phase     = PH_PAYLOAD;
                        remaining = len[31:0];
                    end
                end else if (eob) begin
                    push_verdict(V_TRUNC, 1'b0);
                    restart();
                end
            end else if (phase == PH_PAYLOAD && remaining != 0) begin
                r = '0;
                r.payload_byte = b;
                expected_results = {expected_results, r};
                crc = crc_step(crc, b);
                remaining--;
                if (remaining == 0) begin
                    v = crc_verdict();
                    push_verdict(v, 1'b1);
                    close_record(v, eob);
                end else if (eob) begin
                    push_verdict(V_TRUNC, 1'b1);
                    restart();
                end
            end else if (eob) begin
                restart();
            end
            if (expected_results.size() > n_prior) begin
                expected_results[expected_results.size() - 1].last_of_run = 1'b1;
            end
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                failures++;
                if (failures <= 10) begin
                    $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name,
                             want, got);
                end
            end
        endfunction

        function void match_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("%0t: unexpected result, kind %0d byte %0h verdict %0d",
                             $realtime, got.result_kind, got.payload_byte, got.verdict);
                end
                return;
            end
            want = expected_results.pop_front();
            compare_field("result_kind", want.result_kind, got.result_kind);
            compare_field("payload_byte", want.payload_byte, got.payload_byte);
            compare_field("verdict", want.verdict, got.verdict);
            compare_field("record_kind", want.record_kind, got.record_kind);
            compare_field("sequence_number", want.sequence_number, got.sequence_number);
            compare_field("transaction_id", want.transaction_id, got.transaction_id);
            compare_field("payload_length", want.payload_length, got.payload_length);
            compare_field("last_of_run", want.last_of_run, got.last_of_run);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    jrd_in_if  in_if ();
    jrd_out_if out_if ();

    journal_record_deframer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    record_ledger ledger = new();

    logic [7:0]  frame_bytes[$];
    logic [31:0] cur_magic;
    logic [15:0] cur_version;
    logic [31:0] cur_bound;
    int          bytes_sent = 0;
    int          hold_cycles = 0;
    bit          calm = 1'b0;
    int          quiet;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                ledger.take_byte(in_if.stream_byte, in_if.end_of_buffer);
            end
            if (out_if.valid && out_if.ready) begin
                got.result_kind     = out_if.result_kind;
                got.payload_byte    = out_if.payload_byte;
                got.verdict         = t_verdict'(out_if.verdict);
                got.record_kind     = out_if.record_kind;
                got.sequence_number = out_if.sequence_number;
                got.transaction_id  = out_if.transaction_id;
                got.payload_length  = out_if.payload_length;
                got.last_of_run     = out_if.last_of_run;
                ledger.match_result(got);
            end
        end
    end

    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                out_if.ready <= 1'b0;
                hold_cycles--;
            end else begin
                out_if.ready <= calm || ($urandom_range(99) >= 16);
            end
        end
    end

    initial begin
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        ledger.set_reg(idx, data);
    endtask

    task automatic program_regs(logic [31:0] magic, logic [15:0] version, logic [31:0] bound);
        write_reg(CFG_MAGIC, magic);
        write_reg(CFG_VERSION, {16'd0, version});
        write_reg(CFG_BOUND, bound);
        i_cfg_we    <= 1'b0;
        cur_magic   = magic;
        cur_version = version;
        cur_bound   = bound;
    endtask

    task automatic send_byte(logic [7:0] b, logic eob);
        while (!calm && $urandom_range(99) < 16) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.stream_byte   <= b;
        in_if.end_of_buffer <= eob;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Sends the first cut bytes of the frame (all of it when cut is zero),
    // marking the last one sent as the end of the buffer.
    task automatic send_frame(int cut);
        int n;
        n = (cut == 0) ? frame_bytes.size() : cut;
        for (int i = 0; i < n; i++) begin
            send_byte(frame_bytes[i], i == n - 1);
        end
        frame_bytes.delete();
    endtask

    task automatic wait_settled();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (ledger.expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic add_record(t_flaw flaw, logic [31:0] len, int pay_n, logic [15:0] kind,
                              logic [63:0] seq, logic [63:0] txid, int fill);
        logic [7:0]   pay[$];
        logic [31:0]  magic;
        logic [31:0]  flags;
        logic [31:0]  crc;
        logic [15:0]  version;
        logic [287:0] hv;
        magic   = cur_magic;
        version = cur_version;
        flags   = '0;
        case (flaw)
            FLAW_MAGIC: begin
                magic = cur_magic ^ ($urandom | (32'd1 << $urandom_range(31, 0)));
            end
            FLAW_VERSION: begin
                version = cur_version ^ 16'($urandom_range(65535, 1));
            end
            FLAW_FLAGS: begin
                flags = $urandom | (32'd1 << $urandom_range(31, 0));
            end
            default: begin
            end
        endcase
        for (int i = 0; i < pay_n; i++) begin
            pay = {pay, ((fill < 0) ? 8'($urandom) : 8'(fill))};
        end
        hv  = {32'd0, len, txid, seq, flags, kind, version, magic};
        crc = CRC_INIT;
        for (int i = 0; i < CRC_SPAN; i++) begin
            crc = record_ledger::crc_step(crc, hv[8*i +: 8]);
        end
        foreach (pay[i]) crc = record_ledger::crc_step(crc, pay[i]);
        crc = ~crc;
        if (flaw == FLAW_CRC) crc = crc ^ ($urandom | 32'd1);
        hv[287:256] = crc;
        for (int i = 0; i < HEADER_BYTES; i++) begin
            frame_bytes = {frame_bytes, hv[8*i +: 8]};
        end
        foreach (pay[i]) frame_bytes = {frame_bytes, pay[i]};
    endtask

    task automatic random_buffer();
        int          nrec;
        int          pick;
        int          pay_n;
        int          cut;
        logic [31:0] len;
        logic [63:0] txid;
        t_flaw       flaw;
        bit          stop;
        if ($urandom_range(99) < 6) begin
            repeat ($urandom_range(60, 1)) frame_bytes = {frame_bytes, 8'($urandom)};
            send_frame(0);
            return;
        end
        nrec = $urandom_range(2, 1);
        stop = 1'b0;
        for (int r = 0; r < nrec && !stop; r++) begin
            pick  = $urandom_range(99);
            len   = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 0);
            flaw  = FLAW_NONE;
            if (pick < 6) begin
                flaw = FLAW_MAGIC;
            end else if (pick < 12) begin
                flaw = FLAW_VERSION;
            end else if (pick < 18) begin
                flaw = FLAW_FLAGS;
            end else if (pick < 26) begin
                flaw = FLAW_CRC;
            end else if (pick < 31 && cur_bound < 40) begin
                len = cur_bound + 1 + $urandom_range(3, 0);
            end else if (pick >= 31 && pick < 36) begin
                // Huge length; the buffer ends after at most eight payload bytes.
                len  = $urandom | 32'h100;
                stop = 1'b1;
            end
            pay_n = stop ? $urandom_range(8, 0) : int'(len);
            txid  = ($urandom_range(3) == 0) ? 64'd0 : {$urandom, $urandom};
            add_record(flaw, len, pay_n, 16'($urandom), {$urandom, $urandom}, txid, -1);
        end
        cut = ($urandom_range(99) < 15) ? $urandom_range(frame_bytes.size(), 1) : 0;
        send_frame(cut);
    endtask

    task automatic run_phase(int target);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < target) random_buffer();
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_index         <= '0;
        i_cfg_data          <= '0;
        in_if.valid         <= 1'b0;
        in_if.stream_byte   <= '0;
        in_if.end_of_buffer <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        program_regs(32'h4A52_4E4C, 16'h0002, 32'd16);
        add_record(FLAW_NONE, 32'd0, 0, 16'h0001, 64'd1, 64'd0, -1);
        send_frame(1);
        add_record(FLAW_NONE, 32'd0, 0, 16'hFFFF, '1, '1, -1);
        send_frame(0);
        add_record(FLAW_NONE, 32'd1, 1, 16'h0000, 64'd0, 64'd0, 8'h00);
        add_record(FLAW_NONE, 32'd16, 16, 16'h8001, 64'h8000_0000_0000_0001, 64'd7, 8'hFF);
        add_record(FLAW_NONE, 32'd5, 5, 16'h0002, 64'd3, 64'd0, -1);
        send_frame(frame_bytes.size() - 5);
        add_record(FLAW_CRC, 32'd3, 3, 16'h0003, 64'd4, 64'd9, -1);
        add_record(FLAW_NONE, 32'd2, 2, 16'h0004, 64'd5, 64'd0, -1);
        send_frame(0);
        add_record(FLAW_MAGIC, 32'd0, 0, 16'h0005, 64'd6, 64'd0, -1);
        send_frame(0);
        add_record(FLAW_VERSION, 32'd2, 2, 16'h0006, 64'd7, 64'd0, -1);
        add_record(FLAW_NONE, 32'd0, 0, 16'h0007, 64'd8, 64'd0, -1);
        send_frame(0);
        add_record(FLAW_FLAGS, 32'd0, 0, 16'h0008, 64'd9, 64'd0, -1);
        add_record(FLAW_NONE, 32'd1, 1, 16'h0009, 64'd10, 64'd0, -1);
        send_frame(0);
        add_record(FLAW_NONE, 32'd17, 17, 16'h000A, 64'd11, 64'd0, -1);
        add_record(FLAW_NONE, 32'd0, 0, 16'h000B, 64'd12, 64'd0, -1);
        send_frame(0);
        add_record(FLAW_NONE, 32'd4, 4, 16'h000C, 64'd13, 64'd5, -1);
        send_frame(HEADER_BYTES + 2);
        wait_settled();

        program_regs(32'd0, 16'd0, 32'd0);
        run_phase(20);
        wait_settled();

        program_regs('1, '1, '1);
        run_phase(20);
        wait_settled();

        program_regs($urandom, 16'($urandom), 32'd24);
        calm = 1'b1;
        hold_cycles = HOLD_CYCLES;
        run_phase(80);
        calm = 1'b0;
        wait_settled();

        program_regs($urandom, 16'($urandom), $urandom | 32'd64);
        run_phase(20);
        wait_settled();

        program_regs(MAGIC_RESET, VERSION_RESET, BOUND_RESET);
        run_phase(20);
        wait_settled();

        if (ledger.failures == 0 && ledger.expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
